// File: design/bffa_pkg.sv
// Shared constants, types and a helper function of the first-fit bitmap allocator.
package bffa_pkg;

	localparam int MAP_BYTES     = 512;
	localparam int BITS_PER_BYTE = 8;
	localparam int MAP_BITS      = MAP_BYTES * BITS_PER_BYTE;

	localparam int WORD_BITS  = 64;
	localparam int WORD_SHIFT = 6;
	localparam int BYTE_SHIFT = 3;
	localparam int WORD_BYTES = WORD_BITS / BITS_PER_BYTE;
	localparam int NUM_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int ROW_CNT_W  = $clog2(NUM_WORDS + 1);

	localparam int LIMIT_W  = 13;
	localparam int INDEX_W  = 12;
	localparam int MAP_CNT_W = $clog2(MAP_BITS + 1);
	localparam int CNT_W    = (MAP_CNT_W > LIMIT_W) ? MAP_CNT_W : LIMIT_W;
	localparam int ENTRY_W  = ROW_AW + WORD_SHIFT;
	localparam int WIDE_W   = CNT_W + INDEX_W + ENTRY_W;

	localparam int LIMIT_RESET  = 4096;
	localparam int USABLE_RESET = (LIMIT_RESET < MAP_BITS) ? LIMIT_RESET : MAP_BITS;
	localparam int NROWS_RESET  = (USABLE_RESET + WORD_BITS - 1) / WORD_BITS;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef struct packed {
		logic req_load;
		logic scan_clear;
		logic scan_run;
		logic free_read;
		logic free_write;
		logic range_fail;
		logic none_fail;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic found;
		logic none;
		logic range_err;
		logic out_free;
	} dp_stat_t;

	// Position of the lowest set bit of a word, searched per byte and then across bytes.
	function automatic logic [WORD_SHIFT-1:0] first_set_pos(input logic [WORD_BITS-1:0] vec);
		logic [BYTE_SHIFT-1:0] byte_pos [WORD_BYTES];
		logic [WORD_BYTES-1:0] byte_any;
		logic [WORD_SHIFT-1:0] pos;
		pos = '0;
		for (int g = 0; g < WORD_BYTES; g++) begin
			byte_any[g] = |vec[g*BITS_PER_BYTE +: BITS_PER_BYTE];
			byte_pos[g] = '0;
			for (int b = BITS_PER_BYTE - 1; b >= 0; b--) begin
				if (vec[g*BITS_PER_BYTE + b]) begin
					byte_pos[g] = BYTE_SHIFT'(b);
				end
			end
		end
		for (int g = WORD_BYTES - 1; g >= 0; g--) begin
			if (byte_any[g]) begin
				pos = {(WORD_SHIFT-BYTE_SHIFT)'(g), byte_pos[g]};
			end
		end
		return pos;
	endfunction

endpackage

// File: design/bffa_ctrl.sv
// Controller state machine that sequences allocate scans and free updates.
module bffa_ctrl
	import bffa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     mode,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_SCAN     = 5'b00010,
		S_FREE_CHK = 5'b00100,
		S_FREE_WR  = 5'b01000,
		S_DONE     = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load   = 1'b1;
					cmd.scan_clear = 1'b1;
					state_d        = mode ? S_FREE_CHK : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.found) begin
					state_d = S_DONE;
				end else if (stat.none) begin
					cmd.none_fail = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_FREE_CHK: begin
				if (stat.range_err) begin
					cmd.range_fail = 1'b1;
					state_d        = S_DONE;
				end else begin
					cmd.free_read = 1'b1;
					state_d       = S_FREE_WR;
				end
			end
			S_FREE_WR: begin
				cmd.free_write = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/bffa_datapath.sv
// Datapath with the occupancy memory, scan pointer, bit search, result and output registers.
module bffa_datapath
	import bffa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [INDEX_W-1:0] entry_index,
	input  logic               entry_limit_we,
	input  logic [LIMIT_W-1:0] entry_limit,
	input  ctl_cmd_t           cmd,
	output dp_stat_t           stat,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [INDEX_W-1:0] result_index
);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] row_vld_q;
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_vld_q;

	logic [CNT_W-1:0]     usable_q;
	logic [ROW_CNT_W-1:0] nrows_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [ROW_CNT_W-1:0] row_q;
	logic [ROW_CNT_W-1:0] chk_row_s1;
	logic                 chk_vld_s1;
	status_t              res_status_q;
	logic [INDEX_W-1:0]   res_index_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [INDEX_W-1:0]   out_index_q;

	logic [WIDE_W-1:0]    cfg_wide;
	logic [WIDE_W-1:0]    cfg_usable;
	logic [WIDE_W-1:0]    cfg_rows;
	logic [WIDE_W-1:0]    usable_wide;
	logic [WIDE_W-1:0]    base_wide;
	logic [WIDE_W-1:0]    rem_wide;
	logic [WIDE_W-1:0]    idx_wide;
	logic [WIDE_W-1:0]    entry_wide;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] row_mask;
	logic [WORD_BITS-1:0] free_vec;
	logic [WORD_SHIFT-1:0] hit_pos;
	logic                 row_avail;
	logic                 last_row;
	logic [ROW_AW-1:0]    free_row;
	logic [ROW_AW-1:0]    rd_addr;
	logic                 wr_en;
	logic [ROW_AW-1:0]    wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	// Configuration: clamp the limit to the map size and derive the row count.
	assign cfg_wide   = WIDE_W'(entry_limit);
	assign cfg_usable = (cfg_wide < WIDE_W'(MAP_BITS)) ? cfg_wide : WIDE_W'(MAP_BITS);
	assign cfg_rows   = (cfg_usable + WIDE_W'(WORD_BITS - 1)) >> WORD_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= CNT_W'(USABLE_RESET);
			nrows_q  <= ROW_CNT_W'(NROWS_RESET);
		end else if (entry_limit_we) begin
			usable_q <= cfg_usable[CNT_W-1:0];
			nrows_q  <= cfg_rows[ROW_CNT_W-1:0];
		end
	end

	// Row under examination: mask off bits at or above the usable range.
	assign usable_wide = WIDE_W'(usable_q);
	assign base_wide   = WIDE_W'(chk_row_s1) << WORD_SHIFT;
	assign rem_wide    = usable_wide - base_wide;
	assign rd_word     = rd_vld_q ? rd_data_q : '0;

	always_comb begin
		if (usable_wide <= base_wide) begin
			row_mask = '0;
		end else if (rem_wide >= WIDE_W'(WORD_BITS)) begin
			row_mask = '1;
		end else begin
			row_mask = (WORD_BITS'(1) << rem_wide[WORD_SHIFT-1:0]) - WORD_BITS'(1);
		end
	end

	assign free_vec   = ~rd_word & row_mask;
	assign hit_pos    = first_set_pos(free_vec);
	assign entry_wide = WIDE_W'({chk_row_s1[ROW_AW-1:0], hit_pos});
	assign row_avail  = (row_q < nrows_q);
	assign last_row   = ((ROW_CNT_W+1)'(chk_row_s1) + (ROW_CNT_W+1)'(1))
		== (ROW_CNT_W+1)'(nrows_q);

	// Free request decode.
	assign idx_wide = WIDE_W'(idx_q);
	assign free_row = idx_wide[WORD_SHIFT +: ROW_AW];

	assign stat.found     = chk_vld_s1 && (|free_vec);
	assign stat.none      = (nrows_q == '0) || (chk_vld_s1 && !(|free_vec) && last_row);
	assign stat.range_err = (idx_wide >= usable_wide);
	assign stat.out_free  = !out_valid_q || !out_stall;

	// Memory port selection.
	assign rd_addr = cmd.free_read ? free_row : row_q[ROW_AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = free_row;
		wr_data = rd_word & ~(WORD_BITS'(1) << idx_q[WORD_SHIFT-1:0]);
		if (cmd.free_write) begin
			wr_en = 1'b1;
		end else if (cmd.scan_run && stat.found) begin
			wr_en   = 1'b1;
			wr_addr = chk_row_s1[ROW_AW-1:0];
			wr_data = rd_word | (WORD_BITS'(1) << hit_pos);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
		rd_vld_q  <= row_vld_q[rd_addr];
	end

	// A row that was never written reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Scan pointer and check stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			chk_vld_s1 <= 1'b0;
		end else if (cmd.scan_clear) begin
			row_q      <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= cmd.scan_run && row_avail;
			if (cmd.scan_run && row_avail) begin
				row_q <= row_q + ROW_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_row_s1 <= row_q;
		if (cmd.req_load) begin
			idx_q <= entry_index;
		end
		if (cmd.scan_run && stat.found) begin
			res_status_q <= ST_OK;
			res_index_q  <= entry_wide[INDEX_W-1:0];
		end else if (cmd.none_fail) begin
			res_status_q <= ST_NO_SPACE;
			res_index_q  <= '0;
		end else if (cmd.range_fail) begin
			res_status_q <= ST_RANGE;
			res_index_q  <= idx_q;
		end else if (cmd.free_write) begin
			res_status_q <= ST_OK;
			res_index_q  <= idx_q;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign result_index = out_index_q;

endmodule

// File: design/bitmap_first_free_allocator.sv
// Top level of the first-fit bitmap allocator: controller and datapath.
//
//   channel   valid / stall          payload                     width
//   input     in_valid / in_stall    mode, entry_index           1, 12
//   output    out_valid / out_stall  status, result_index        2, 12
//   config    entry_limit_we         entry_limit                 13
//
// One word is in flight at a time; the occupancy map is read one 64-bit row per cycle.
// An allocate scans rows up to the first with a free entry, or all 64 rows of a full
// 4096-entry map when none is free; a free checks the index range, then reads the row and
// writes it back with the bit cleared, and an out-of-range index skips the read and write.
// Reset clears per-row valid flags at once, so no clearing pass is needed.
// A result waiting under out_stall lets the next word in; that word's result then
// waits in the datapath until the output register is free.
module bitmap_first_free_allocator
	import bffa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [INDEX_W-1:0] entry_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [INDEX_W-1:0] result_index,
	input  logic               entry_limit_we,
	input  logic [LIMIT_W-1:0] entry_limit
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	bffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd)
	);

	bffa_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.entry_index    (entry_index),
		.entry_limit_we (entry_limit_we),
		.entry_limit    (entry_limit),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.result_index   (result_index)
	);

endmodule

// File: test/testbench.sv
// Self-checking testbench for the first-fit bitmap allocator.
module testbench;
	import bffa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT   = 2000;
	localparam int FULL_LIMIT    = 200;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] index;
	} map_result_t;

	typedef enum logic [1:0] {RX_FREE_RUN, RX_LIGHT, RX_HEAVY, RX_BLOCK} rx_style_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	logic [INDEX_W-1:0] entry_index;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic [INDEX_W-1:0] result_index;
	logic               entry_limit_we;
	logic [LIMIT_W-1:0] entry_limit;

	logic [MAP_BITS-1:0] occupancy;
	logic [LIMIT_W-1:0]  limit_now;
	map_result_t         awaited_results[$];
	logic [INDEX_W-1:0]  held_entries[$];
	status_t             last_status;
	int                  burst_left;
	int                  errors;
	int                  n_alloc_ok;
	int                  n_no_space;
	int                  n_freed;
	int                  n_range;
	int                  n_limit_writes;

	bitmap_first_free_allocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.entry_index    (entry_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.result_index   (result_index),
		.entry_limit_we (entry_limit_we),
		.entry_limit    (entry_limit)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int usable_entries();
		return (int'(limit_now) < MAP_BITS) ? int'(limit_now) : MAP_BITS;
	endfunction

	function automatic map_result_t occupancy_update(input logic op, input logic [INDEX_W-1:0] idx);
		map_result_t r;
		int          usable;
		usable = usable_entries();
		r.status = ST_NO_SPACE;
		r.index = '0;
		if (op == MODE_FREE) begin
			r.index = idx;
			if (int'(idx) >= usable) begin
				r.status = ST_RANGE;
			end else begin
				occupancy[idx] = 1'b0;
				r.status = ST_OK;
			end
		end else begin
			for (int e = 0; e < usable; e++) begin
				if (!occupancy[e]) begin
					occupancy[e] = 1'b1;
					r.status = ST_OK;
					r.index = INDEX_W'(e);
					break;
				end
			end
		end
		return r;
	endfunction

	task automatic send_word(input logic op, input logic [INDEX_W-1:0] idx);
		map_result_t r;
		int          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= op;
		entry_index <= idx;
		do @(posedge clk); while (in_stall);
		burst_left--;
		r = occupancy_update(op, idx);
		awaited_results.push_back(r);
		last_status = r.status;
		case (r.status)
			ST_OK: begin
				if (op == MODE_ALLOC) begin
					n_alloc_ok++;
					held_entries.push_back(r.index);
				end else begin
					n_freed++;
				end
			end
			ST_NO_SPACE: n_no_space++;
			default: n_range++;
		endcase
	endtask

	task automatic hold_until_drained();
		if (in_valid) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		burst_left = 0;
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] value);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		entry_limit_we <= 1'b1;
		entry_limit <= value;
		@(negedge clk);
		entry_limit_we <= 1'b0;
		limit_now = value;
		n_limit_writes++;
	endtask

	task automatic test_directed();
		send_word(MODE_ALLOC, '1);
		send_word(MODE_ALLOC, '0);
		send_word(MODE_ALLOC, 12'h5a5);
		send_word(MODE_FREE, 12'd1);
		send_word(MODE_FREE, 12'd1);
		send_word(MODE_ALLOC, 12'ha5a);
		send_word(MODE_FREE, '1);
		send_word(MODE_FREE, '0);
		send_word(MODE_ALLOC, '0);
		set_limit('0);
		send_word(MODE_ALLOC, '0);
		send_word(MODE_FREE, '0);
		send_word(MODE_FREE, '1);
		set_limit(LIMIT_W'(1));
		send_word(MODE_ALLOC, '0);
		send_word(MODE_FREE, '0);
		send_word(MODE_ALLOC, '0);
		send_word(MODE_ALLOC, '0);
		send_word(MODE_FREE, 12'd1);
		set_limit('1);
		send_word(MODE_FREE, '1);
		send_word(MODE_FREE, 12'd2);
		send_word(MODE_ALLOC, '1);
		send_word(MODE_ALLOC, '1);
	endtask

	task automatic test_full_map();
		set_limit(LIMIT_W'(FULL_LIMIT));
		do send_word(MODE_ALLOC, INDEX_W'($urandom)); while (last_status != ST_NO_SPACE);
		send_word(MODE_FREE, '1);
		send_word(MODE_FREE, 12'd2047);
		send_word(MODE_FREE, 12'd64);
		send_word(MODE_FREE, 12'd63);
		send_word(MODE_FREE, '0);
		repeat (6) send_word(MODE_ALLOC, INDEX_W'($urandom));
	endtask

	task automatic test_random_traffic(input logic [LIMIT_W-1:0] limit_value, input int count);
		int                 pick;
		int                 k;
		int                 near;
		logic [INDEX_W-1:0] idx;
		set_limit(limit_value);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			idx = INDEX_W'($urandom);
			if (pick < 55) begin
				send_word(MODE_ALLOC, idx);
			end else begin
				if (pick < 75 && held_entries.size() != 0) begin
					k = $urandom_range(0, held_entries.size() - 1);
					idx = held_entries[k];
					held_entries.delete(k);
				end else if (pick >= 85 && pick < 93) begin
					near = int'(limit_now) + $urandom_range(0, 2) - 1;
					idx = (near < 0) ? '0 : (near > MAP_BITS - 1) ? '1 : INDEX_W'(near);
				end else if (pick >= 93 && usable_entries() > 0) begin
					idx = INDEX_W'($urandom_range(0, usable_entries() - 1));
				end
				send_word(MODE_FREE, idx);
			end
			if ($urandom_range(0, 60) == 0) begin
				hold_until_drained();
			end
		end
	endtask

	initial begin
		rx_style_t style;
		int        span;
		int        hold;
		out_stall = 1'b0;
		forever begin
			style = rx_style_t'($urandom_range(0, 3));
			span = $urandom_range(16, 96);
			hold = $urandom_range(8, 40);
			for (int c = 0; c < span; c++) begin
				@(negedge clk);
				case (style)
					RX_FREE_RUN: out_stall <= 1'b0;
					RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= (c < hold);
				endcase
			end
		end
	end

	initial begin
		map_result_t want;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected word status=%0d index=%0d", $realtime, status,
						result_index);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $realtime, want.status,
							status);
						errors++;
					end
					if (result_index !== want.index) begin
						$display("%0t: result_index expected %0d, got %0d", $realtime,
							want.index, result_index);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ALLOC;
		entry_index = '0;
		entry_limit_we = 1'b0;
		entry_limit = '0;
		occupancy = '0;
		limit_now = LIMIT_W'(LIMIT_RESET);
		burst_left = 0;
		errors = 0;
		n_alloc_ok = 0;
		n_no_space = 0;
		n_freed = 0;
		n_range = 0;
		n_limit_writes = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_map();
		test_random_traffic(LIMIT_W'(4096), 80);
		test_random_traffic(LIMIT_W'(70), 60);
		test_random_traffic('1, 60);
		test_random_traffic('0, 30);
		test_random_traffic(LIMIT_W'(65), 60);
		test_random_traffic(LIMIT_W'(1), 40);
		test_random_traffic(LIMIT_W'(4095), 70);
		test_random_traffic(LIMIT_W'($urandom_range(0, 8191)), 60);
		test_random_traffic(LIMIT_W'(64), 60);
		test_random_traffic(LIMIT_W'(4096), 80);

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Allocations: %0d granted, %0d refused for lack of space.", n_alloc_ok,
			n_no_space);
		$display("Frees: %0d done, %0d out of range; %0d limit writes.", n_freed, n_range,
			n_limit_writes);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
